### design/yc2rgb_pkg.sv
`default_nettype none
// ============================================================================
// yc2rgb_pkg - shared types and constants of the YCbCr 4:2:2 to RGB converter
// Pixel structs for both stream directions and the fixed constants of the
// BT.601 full-range color matrix.
// ============================================================================
package yc2rgb_pkg;

  // Default fraction bits of the color matrix coefficients.
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  // Offset of the chroma samples and top of the output range.
  localparam int unsigned CHROMA_OFFSET = 128;
  localparam int unsigned CHANNEL_MAX   = 255;

  // One input pixel.
  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic       row_start;
  } yc_pixel_t;

  // One output pixel, in RGB or BGR order.
  typedef struct packed {
    logic [7:0] first_channel;
    logic [7:0] green_channel;
    logic [7:0] third_channel;
  } rgb_pixel_t;

endpackage : yc2rgb_pkg
`default_nettype wire

### design/yc2rgb_matrix.sv
`default_nettype none
// ============================================================================
// yc2rgb_matrix - BT.601 full-range color matrix
// Combinational conversion of one Y/Cb/Cr triple to clamped 8-bit R, G, B
// with fixed-point coefficients, plus the RGB/BGR order select.
// ============================================================================
module yc2rgb_matrix #(
  parameter int unsigned CoefFracBits = yc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic [7:0]             luma_i,
  input  logic [7:0]             cb_i,
  input  logic [7:0]             cr_i,
  input  logic                   blue_first_i,
  output yc2rgb_pkg::rgb_pixel_t pixel_o
);
  import yc2rgb_pkg::*;

  // Sums span roughly -300..+500 in whole units: 11 integer bits, signed.
  localparam int unsigned AccW = CoefFracBits + 11;

  localparam longint CoefRL  = ((64'(1402)  << CoefFracBits) + 64'(500))   / 64'(1000);
  localparam longint CoefGbL = ((64'(34414) << CoefFracBits) + 64'(50000)) / 64'(100000);
  localparam longint CoefGrL = ((64'(71414) << CoefFracBits) + 64'(50000)) / 64'(100000);
  localparam longint CoefBL  = ((64'(1772)  << CoefFracBits) + 64'(500))   / 64'(1000);

  localparam logic signed [AccW-1:0] CoefR  = AccW'(CoefRL);
  localparam logic signed [AccW-1:0] CoefGb = AccW'(CoefGbL);
  localparam logic signed [AccW-1:0] CoefGr = AccW'(CoefGrL);
  localparam logic signed [AccW-1:0] CoefB  = AccW'(CoefBL);

  localparam logic [7:0] ChromaOffset = 8'(CHROMA_OFFSET);
  localparam logic [7:0] ChannelMax   = 8'(CHANNEL_MAX);

  logic signed [8:0]      db;
  logic signed [8:0]      dr;
  logic signed [AccW-1:0] db_ext;
  logic signed [AccW-1:0] dr_ext;
  logic signed [AccW-1:0] ys;
  logic signed [AccW-1:0] sum_r;
  logic signed [AccW-1:0] sum_g;
  logic signed [AccW-1:0] sum_b;
  logic [7:0]             red;
  logic [7:0]             green;
  logic [7:0]             blue;

  // Floor to whole units and clamp to 0..255.
  function automatic logic [7:0] floor_clamp(logic signed [AccW-1:0] v);
    logic [10:0] whole;
    whole = v[AccW-1:CoefFracBits];
    if (whole[10]) begin
      floor_clamp = 8'd0;
    end else if (whole[9:8] != 2'b00) begin
      floor_clamp = ChannelMax;
    end else begin
      floor_clamp = whole[7:0];
    end
  endfunction

  assign db     = signed'({1'b0, cb_i}) - signed'({1'b0, ChromaOffset});
  assign dr     = signed'({1'b0, cr_i}) - signed'({1'b0, ChromaOffset});
  assign db_ext = AccW'(db);
  assign dr_ext = AccW'(dr);
  assign ys     = signed'({3'b000, luma_i, {CoefFracBits{1'b0}}});

  assign sum_r = ys + CoefR * dr_ext;
  assign sum_g = ys - CoefGb * db_ext - CoefGr * dr_ext;
  assign sum_b = ys + CoefB * db_ext;

  assign red   = floor_clamp(sum_r);
  assign green = floor_clamp(sum_g);
  assign blue  = floor_clamp(sum_b);

  assign pixel_o.first_channel = blue_first_i ? blue : red;
  assign pixel_o.green_channel = green;
  assign pixel_o.third_channel = blue_first_i ? red : blue;

endmodule : yc2rgb_matrix
`default_nettype wire

### design/ycbcr422_to_rgb_converter_core.sv
`default_nettype none
// ============================================================================
// ycbcr422_to_rgb_converter_core - YCbCr 4:2:2 to RGB pixel converter
// Pairs luma with the chroma pair of its column pair and converts each pixel
// to full-range BT.601 RGB (or BGR), one pixel per clock unless stalled.
// ============================================================================
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  in      | sink      | in_valid_i/in_stall_o | yc_pixel_t  (Y, Cb, Cr, SOL)
//  out     | source    | out_valid_o/out_stall_i | rgb_pixel_t (3 x 8 bit)
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | blue_first (1 bit)
//
//  An accepted pixel lands in the input register; the color matrix converts
//  it and the output register loads it once free, which raises out_valid_o.
//  One pixel per clock is sustained while out_stall_i is low; the two stages
//  advance as a pipeline. in_stall_o rises only while both stages are full
//  and out_stall_i is high. Reset clears the column parity, the held chroma,
//  the order select and all valid flags; no pixel is lost or repeated across
//  stalls.
//
module ycbcr422_to_rgb_converter_core #(
  parameter int unsigned CoefFracBits = yc2rgb_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // pixel request in
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  yc2rgb_pkg::yc_pixel_t  in_data_i,
  // pixel request out
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output yc2rgb_pkg::rgb_pixel_t out_data_o,
  // configuration write
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);
  import yc2rgb_pkg::*;

  logic       blue_first_q;
  logic       odd_column_q;
  logic [7:0] held_cb_q;
  logic [7:0] held_cr_q;

  logic       s0_valid_q;
  logic [7:0] s0_luma_q;
  logic [7:0] s0_cb_q;
  logic [7:0] s0_cr_q;

  logic       out_valid_q;
  rgb_pixel_t out_data_q;

  logic       out_load;
  logic       in_accept;
  logic       even_column;
  logic [7:0] sel_cb;
  logic [7:0] sel_cr;
  rgb_pixel_t matrix_pixel;

  // Output register is free when empty or being drained this cycle.
  assign out_load   = !out_valid_q || !out_stall_i;
  // Hold the input only when the input register cannot move on.
  assign in_stall_o = s0_valid_q && !out_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Row start forces an even column; otherwise the parity alternates.
  assign even_column = in_data_i.row_start || !odd_column_q;
  assign sel_cb      = even_column ? in_data_i.chroma_blue : held_cb_q;
  assign sel_cr      = even_column ? in_data_i.chroma_red  : held_cr_q;

  // Configuration must be written only while idle; the core does not enforce it, so take it every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blue_first_q <= 1'b0;
    end else if (cfg_valid_i) begin
      blue_first_q <= cfg_data_i;
    end
  end

  // Column parity and held chroma pair advance on every accepted pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_column_q <= 1'b0;
      held_cb_q    <= 8'd0;
      held_cr_q    <= 8'd0;
    end else if (in_accept) begin
      odd_column_q <= even_column;
      held_cb_q    <= sel_cb;
      held_cr_q    <= sel_cr;
    end
  end

  // Input register: refill whenever it is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s0_luma_q <= in_data_i.luma;
      s0_cb_q   <= sel_cb;
      s0_cr_q   <= sel_cr;
    end
  end

  yc2rgb_matrix #(
    .CoefFracBits(CoefFracBits)
  ) u_matrix (
    .luma_i      (s0_luma_q),
    .cb_i        (s0_cb_q),
    .cr_i        (s0_cr_q),
    .blue_first_i(blue_first_q),
    .pixel_o     (matrix_pixel)
  );

  // Output register: load the converted pixel when free, hold under stall.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s0_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s0_valid_q) begin
      out_data_q <= matrix_pixel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : ycbcr422_to_rgb_converter_core
`default_nettype wire

### design/yc2rgb_checker.sv
`default_nettype none
// ============================================================================
// yc2rgb_checker - port-level checks of the YCbCr to RGB converter
// Watches the top-level ports for stall, latency, hold and config writes.
// ============================================================================
module yc2rgb_checker (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input yc2rgb_pkg::yc_pixel_t  in_data_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input yc2rgb_pkg::rgb_pixel_t out_data_o,
  input logic                   cfg_valid_i,
  input logic                   cfg_ready_o
);

  // Stall the input only when a pixel waits at a stalled output.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  // A new output burst starts only after an accepted, registered request.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("output appeared without a request two cycles before");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled output changed");

  // A stalled input request holds.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(in_data_i)))
    else $error("stalled input request changed");

  // Write the order register only while no pixel waits at the output.
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !out_valid_o)
    else $error("order register written with a pixel in flight");

endmodule : yc2rgb_checker

bind ycbcr422_to_rgb_converter_core yc2rgb_checker u_yc2rgb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o),
  .cfg_valid_i(cfg_valid_i),
  .cfg_ready_o(cfg_ready_o)
);
`default_nettype wire

### test/ycbcr422_to_rgb_converter_core_tb.sv
// ============================================================================
// ycbcr422_to_rgb_converter_core_tb - testbench of the 4:2:2 to RGB converter
// Sends pixel requests through the stall handshake with random gaps on both
// sides. A behavioral predictor tracks column parity, held chroma and the
// channel order and works out each RGB pixel. A checker matches every output
// request against the oldest pending prediction.
// ============================================================================
module ycbcr422_to_rgb_converter_core_tb;
  import yc2rgb_pkg::*;

  localparam int unsigned FRAC         = COEF_FRAC_BITS_DEF;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned PHASE_ITEMS  = 100;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Color matrix coefficients, rounded to nearest at FRAC fraction bits.
  localparam longint K_CR_R = ((64'd1402 << FRAC) + 64'd500) / 64'd1000;
  localparam longint K_CB_G = ((64'd34414 << FRAC) + 64'd50000) / 64'd100000;
  localparam longint K_CR_G = ((64'd71414 << FRAC) + 64'd50000) / 64'd100000;
  localparam longint K_CB_B = ((64'd1772 << FRAC) + 64'd500) / 64'd1000;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  yc_pixel_t  in_data_i;
  logic       out_valid_o;
  logic       out_stall_i;
  rgb_pixel_t out_data_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic       cfg_data_i;

  // Predictor state: column parity, held chroma pair and channel order.
  bit         col_odd;
  logic [7:0] hold_cb;
  logic [7:0] hold_cr;
  bit         order_bgr;

  rgb_pixel_t  expected_pixels[$];
  rgb_pixel_t  want_px;
  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned stall_left;

  ycbcr422_to_rgb_converter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Floor a fixed-point sum (arithmetic shift rounds toward minus infinity)
  // and clamp it to the channel range.
  function automatic logic [7:0] floor_clamp_channel(input longint sum);
    longint whole;
    whole = sum >>> FRAC;
    if (whole < 0) return 8'd0;
    if (whole > longint'(CHANNEL_MAX)) return 8'(CHANNEL_MAX);
    return whole[7:0];
  endfunction

  // Advance column parity and held chroma for one pixel, return its color.
  function automatic rgb_pixel_t predict_rgb(input yc_pixel_t px);
    longint     db;
    longint     dr;
    longint     ys;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    rgb_pixel_t res;
    // A row start forces column zero: relatch chroma and restart parity.
    if (px.row_start) col_odd = 1'b0;
    if (!col_odd) begin
      hold_cb = px.chroma_blue;
      hold_cr = px.chroma_red;
    end
    col_odd = ~col_odd;
    db    = longint'(hold_cb) - longint'(CHROMA_OFFSET);
    dr    = longint'(hold_cr) - longint'(CHROMA_OFFSET);
    ys    = longint'(px.luma) <<< FRAC;
    red   = floor_clamp_channel(ys + K_CR_R * dr);
    green = floor_clamp_channel(ys - K_CB_G * db - K_CR_G * dr);
    blue  = floor_clamp_channel(ys + K_CB_B * db);
    res.first_channel = order_bgr ? blue : red;
    res.green_channel = green;
    res.third_channel = order_bgr ? red : blue;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic yc_pixel_t make_pixel(input logic [7:0] y, input logic [7:0] cb,
                                           input logic [7:0] cr, input logic sol);
    yc_pixel_t px;
    px.luma        = y;
    px.chroma_blue = cb;
    px.chroma_red  = cr;
    px.row_start   = sol;
    return px;
  endfunction

  // Favor the range ends and the chroma zero point, otherwise uniform.
  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'(CHROMA_OFFSET);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0d] mismatch: %s", cycle_count, msg);
    err_count++;
  endtask

  // Offer one pixel request after a random gap; predict it once accepted.
  // Valid is left high after acceptance, so back-to-back requests keep it asserted.
  task automatic send_pixel(input yc_pixel_t px);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    expected_pixels.push_back(predict_rgb(px));
  endtask

  // Drain the pipeline, then write the channel order register.
  task automatic set_order(input bit bgr);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= bgr;
    do @(posedge clk_i); while (!cfg_ready_o);
    order_bgr = bgr;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Without any row start the parity alternates from reset: the first pixel
  // latches, the odd pixel ignores its chroma inputs.
  task automatic test_pairing_from_reset();
    in_gap_max  = 2;
    out_gap_max = 2;
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 1'b0));
  endtask

  // Drive green and blue into both clamp limits and red into its upper one,
  // plus neutral grey and alternating bit patterns.
  task automatic test_clamp_extremes();
    send_pixel(make_pixel(8'd128, 8'd128, 8'd128, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd128, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd0, 1'b1));
    send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 1'b1));
    send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 1'b0));
  endtask

  // A row start landing on an odd column relatches chroma and restarts parity.
  task automatic test_row_start_on_odd();
    send_pixel(make_pixel(8'd10, 8'd200, 8'd50, 1'b1));
    send_pixel(make_pixel(8'd20, 8'd0, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd30, 8'd1, 8'd2, 1'b0));
    send_pixel(make_pixel(8'd40, 8'd90, 8'd160, 1'b0));
  endtask

  // Swap red and blue, then go back to the reset order.
  task automatic test_channel_order();
    set_order(1'b1);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 1'b1));
    send_pixel(make_pixel(8'd200, 8'd7, 8'd7, 1'b0));
    send_pixel(make_pixel(8'd90, 8'd30, 8'd230, 1'b1));
    set_order(1'b0);
    send_pixel(make_pixel(8'd90, 8'd30, 8'd230, 1'b1));
  endtask

  // Phases of well-formed rows of random width (mostly short, odd widths
  // included) mixed with stray pixels whose row start is random. Each phase
  // picks a channel order and an idling mix, some with no idling at all.
  task automatic test_random_rows();
    int unsigned sent;
    int unsigned phase_end;
    int unsigned width;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      set_order($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin in_gap_max = 0; out_gap_max = 0; end
        1: begin in_gap_max = 9; out_gap_max = 0; end
        2: begin in_gap_max = 0; out_gap_max = 9; end
        default: begin in_gap_max = 9; out_gap_max = 9; end
      endcase
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        if ($urandom_range(0, 9) == 0) begin
          send_pixel(make_pixel(rand_sample(), rand_sample(), rand_sample(),
                                1'($urandom_range(0, 1))));
          sent++;
        end else begin
          width = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 64)
                                              : $urandom_range(1, 16);
          for (int unsigned col = 0; col < width; col++) begin
            send_pixel(make_pixel(rand_sample(), rand_sample(), rand_sample(),
                                  col == 0));
          end
          sent += width;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Output side: stall driver and checker
  // --------------------------------------------------------------------------

  // Hold stall for the count drawn at the last accepted output request.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  = stall_left - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      stall_left = $urandom_range(0, out_gap_max);
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("output pixel %h with no request pending", out_data_o));
      end else begin
        want_px = expected_pixels.pop_front();
        if (out_data_o.first_channel !== want_px.first_channel)
          report_mismatch($sformatf("first channel got %0d, expected %0d",
                                    out_data_o.first_channel, want_px.first_channel));
        if (out_data_o.green_channel !== want_px.green_channel)
          report_mismatch($sformatf("green channel got %0d, expected %0d",
                                    out_data_o.green_channel, want_px.green_channel));
        if (out_data_o.third_channel !== want_px.third_channel)
          report_mismatch($sformatf("third channel got %0d, expected %0d",
                                    out_data_o.third_channel, want_px.third_channel));
      end
    end
  end

  // Abort a run that hangs on a handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels pending",
               cycle_count, expected_pixels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 1'b0;
    col_odd     = 1'b0;
    hold_cb     = '0;
    hold_cr     = '0;
    order_bgr   = 1'b0;
    err_count   = 0;
    cycle_count = 0;
    in_gap_max  = 0;
    out_gap_max = 0;
    stall_left  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_pairing_from_reset();
    test_clamp_extremes();
    test_row_start_on_odd();
    test_channel_order();
    test_random_rows();

    // Drop valid, drain, then give stray outputs a chance to show up.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
design/yc2rgb_pkg.sv
design/yc2rgb_matrix.sv
design/ycbcr422_to_rgb_converter_core.sv
design/yc2rgb_checker.sv
test/ycbcr422_to_rgb_converter_core_tb.sv
